### hdl/u16ed_pkg.sv
`timescale 1ns / 1ps

package u16ed_pkg;

   // Payload widths
   localparam int unsigned CharWidth   = 8;
   localparam int unsigned CodeWidth   = 21;
   localparam int unsigned StatusWidth = 4;
   localparam int unsigned HexWidth    = 16;
   localparam int unsigned HighWidth   = 10;

   typedef logic [CharWidth-1:0]   char_type;
   typedef logic [CodeWidth-1:0]   code_type;
   typedef logic [StatusWidth-1:0] status_type;
   typedef logic [HexWidth-1:0]    hex_type;
   typedef logic [HighWidth-1:0]   high_type;

   // Result status codes
   localparam status_type StOk          = 4'd0;
   localparam status_type StEndBefore   = 4'd1;
   localparam status_type StNoU         = 4'd2;
   localparam status_type StBadHex      = 4'd3;
   localparam status_type StEarlyEnd    = 4'd4;
   localparam status_type StLoneLow     = 4'd5;
   localparam status_type StNoBackslash = 4'd6;
   localparam status_type StNoTrailU    = 4'd7;
   localparam status_type StBadTrail    = 4'd8;

   // Characters of the escape syntax
   localparam char_type ChU         = 8'h75;
   localparam char_type ChBackslash = 8'h5C;

   // Surrogate ranges, matched on the upper bits of the 16-bit unit
   localparam logic [4:0] SurAnyTop  = 5'b11011;   // 0xD800..0xDFFF
   localparam logic [5:0] SurHighTop = 6'b110110;  // 0xD800..0xDBFF
   localparam logic [5:0] SurLowTop  = 6'b110111;  // 0xDC00..0xDFFF
   localparam code_type   SuppBase   = 21'h10000;

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value
   function automatic logic [4:0] hex_digit(input char_type c);
      logic [4:0] result;
      result = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         result = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         result = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         result = {1'b1, 4'(c - 8'h37)};
      end
      return result;
   endfunction

endpackage

### hdl/u16ed_req_if.sv
`timescale 1ns / 1ps

interface u16ed_req_if;
   logic                valid;
   logic                ready;
   u16ed_pkg::char_type char_byte;
   logic                stream_end;

   modport source (output valid, output char_byte, output stream_end, input ready);
   modport sink   (input valid, input char_byte, input stream_end, output ready);
endinterface

### hdl/u16ed_rsp_if.sv
`timescale 1ns / 1ps

interface u16ed_rsp_if;
   logic                  valid;
   logic                  ready;
   u16ed_pkg::code_type   code_point;
   u16ed_pkg::status_type status;

   modport source (output valid, output code_point, output status, input ready);
   modport sink   (input valid, input code_point, input status, output ready);
endinterface

### hdl/utf16_escape_decoder_unit.sv
`timescale 1ns / 1ps

// Decodes a JSON \u escape (backslash already consumed), including a
// surrogate pair, from a stream of one character byte or end mark per
// transfer. Takes one transfer every clock cycle when the result side keeps
// up. The result is offered once the item that completes the escape or
// raises an error has moved from the input register into the result
// register. The result register stalls the input side only when it holds
// an untaken result. After each result the decoder waits for a new 'u'.
module utf16_escape_decoder_unit (
   input  logic         clock,
   input  logic         reset,
   u16ed_req_if.sink    req_chan,
   u16ed_rsp_if.source  rsp_chan
);

   typedef enum logic [2:0] {
      PH_FIRST_U,
      PH_LEAD_HEX,
      PH_BACKSLASH,
      PH_TRAIL_U,
      PH_TRAIL_HEX
   } phase_type;

   // Input register
   logic                  in_valid_ff;
   u16ed_pkg::char_type   in_char_ff;
   logic                  in_end_ff;

   // Decoder state
   phase_type             phase_ff, phase_in;
   logic [1:0]            digit_cnt_ff, digit_cnt_in;
   u16ed_pkg::hex_type    hex_accum_ff, hex_accum_in;
   u16ed_pkg::high_type   high_part_ff, high_part_in;

   // Result register
   logic                  out_valid_ff;
   u16ed_pkg::code_type   out_code_ff, out_code_in;
   u16ed_pkg::status_type out_status_ff, out_status_in;
   logic                  emit;

   logic                  advance;
   logic [4:0]            digit;
   u16ed_pkg::hex_type    unit_val;

   // Advance the decode stage when the input register holds an item and the result register is free or draining
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign digit    = u16ed_pkg::hex_digit(in_char_ff);
   assign unit_val = {hex_accum_ff[11:0], digit[3:0]};

   // Next state and result for the item in the input register
   always_comb begin
      phase_in      = phase_ff;
      digit_cnt_in  = digit_cnt_ff;
      hex_accum_in  = hex_accum_ff;
      high_part_in  = high_part_ff;
      emit          = 1'b0;
      out_code_in   = '0;
      out_status_in = u16ed_pkg::StOk;
      unique case (phase_ff)
         PH_LEAD_HEX, PH_TRAIL_HEX: begin
            if (in_end_ff) begin
               emit          = 1'b1;
               out_status_in = u16ed_pkg::StEarlyEnd;
            end else if (!digit[4]) begin
               emit          = 1'b1;
               out_status_in = u16ed_pkg::StBadHex;
            end else if (digit_cnt_ff != 2'd3) begin
               hex_accum_in = unit_val;
               digit_cnt_in = digit_cnt_ff + 2'd1;
            end else if (phase_ff == PH_LEAD_HEX) begin
               // Classify the leading unit
               if (unit_val[15:11] != u16ed_pkg::SurAnyTop) begin
                  emit        = 1'b1;
                  out_code_in = {5'd0, unit_val};
               end else if (unit_val[15:10] == u16ed_pkg::SurLowTop) begin
                  emit          = 1'b1;
                  out_status_in = u16ed_pkg::StLoneLow;
               end else begin
                  high_part_in = unit_val[9:0];
                  phase_in     = PH_BACKSLASH;
                  digit_cnt_in = 2'd0;
               end
            end else begin
               // Combine the pair
               emit = 1'b1;
               if (unit_val[15:10] != u16ed_pkg::SurLowTop) begin
                  out_status_in = u16ed_pkg::StBadTrail;
               end else begin
                  out_code_in = {1'b0, high_part_ff, unit_val[9:0]} + u16ed_pkg::SuppBase;
               end
            end
         end
         PH_BACKSLASH: begin
            if (in_end_ff || in_char_ff != u16ed_pkg::ChBackslash) begin
               emit          = 1'b1;
               out_status_in = u16ed_pkg::StNoBackslash;
            end else begin
               phase_in = PH_TRAIL_U;
            end
         end
         PH_TRAIL_U: begin
            if (in_end_ff || in_char_ff != u16ed_pkg::ChU) begin
               emit          = 1'b1;
               out_status_in = u16ed_pkg::StNoTrailU;
            end else begin
               phase_in     = PH_TRAIL_HEX;
               digit_cnt_in = 2'd0;
            end
         end
         default: begin
            if (in_end_ff) begin
               emit          = 1'b1;
               out_status_in = u16ed_pkg::StEndBefore;
            end else if (in_char_ff != u16ed_pkg::ChU) begin
               emit          = 1'b1;
               out_status_in = u16ed_pkg::StNoU;
            end else begin
               phase_in     = PH_LEAD_HEX;
               digit_cnt_in = 2'd0;
            end
         end
      endcase
      // Drop back to the start after every result
      if (emit) begin
         phase_in     = PH_FIRST_U;
         digit_cnt_in = 2'd0;
      end
   end

   // Hold input, state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_FIRST_U;
         digit_cnt_ff <= 2'd0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= emit;
            phase_ff     <= phase_in;
            digit_cnt_ff <= digit_cnt_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_chan.ready) begin
         in_char_ff <= req_chan.char_byte;
         in_end_ff  <= req_chan.stream_end;
      end
      if (advance) begin
         hex_accum_ff  <= hex_accum_in;
         high_part_ff  <= high_part_in;
         out_code_ff   <= out_code_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.code_point = out_code_ff;
   assign rsp_chan.status     = out_status_ff;

   // An error result never carries a code point
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != u16ed_pkg::StOk |-> out_code_ff == '0)
      else $error("error result with nonzero code point");

   // Every result returns the decoder to the start
   assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> phase_ff == PH_FIRST_U && digit_cnt_ff == 2'd0)
      else $error("decoder did not restart after a result");

   // A stalled result register freezes the decoder state
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_chan.ready |=>
         $stable(phase_ff) && $stable(digit_cnt_ff) && $stable(out_code_ff))
      else $error("decoder moved while result stalled");

   // The digit counter is idle outside the hex phases
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BACKSLASH || phase_ff == PH_TRAIL_U || phase_ff == PH_FIRST_U
         |-> digit_cnt_ff == 2'd0)
      else $error("digit count active outside hex phases");

endmodule
